// ----- hdl/ies_pkg.sv -----
// ----------------------------------------------------------------------------
// ies_pkg
// Shared types and constants of the injector event scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ies_pkg;

	// angles in 1/64 degree
	localparam logic [16:0] DEG360  = 17'd23040;
	localparam logic [16:0] DEG720  = 17'd46080;
	localparam logic [17:0] DEG1440 = 18'd92160;

	// timing constants
	localparam logic [31:0] GUARD_TICKS = 32'd5;
	localparam logic [31:0] WRAP_HIGH   = 32'd2863311531;
	localparam logic [31:0] WRAP_LOW    = 32'd1431655765;
	localparam logic [31:0] RESET_TICK  = 32'd4294967290;

	// register reset values
	localparam logic [3:0]  COUNT_RESET = 4'd4;
	localparam logic [31:0] TPS_RESET   = 32'd1000000;

	// result kinds
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_CANCEL  = 2'd1;
	localparam logic [1:0] ACT_RESCHED = 2'd2;

	// register indexes
	localparam logic [1:0] REG_COUNT    = 2'd0;
	localparam logic [1:0] REG_TDC_LOW  = 2'd1;
	localparam logic [1:0] REG_TDC_HIGH = 2'd2;
	localparam logic [1:0] REG_TPS      = 2'd3;

	// stream widths
	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 72;

	// classified request passed from front to back
	typedef struct packed {
		logic [2:0]  inj;
		logic        eligible;
		logic        zero_pulse;
		logic [15:0] ang_dist;
		logic [23:0] tpd;
		logic [31:0] now;
		logic [23:0] pulse;
	} item_t;

endpackage

`default_nettype wire

// ----- hdl/injector_event_scheduler.sv -----
// ----------------------------------------------------------------------------
// injector_event_scheduler
// Turns injector reschedule requests into open and close timer ticks.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream, one per injector to reschedule; each
// gives exactly one result on the m_ stream, in request order. m_tuser holds
// the action (no change, cancel, reschedule) and m_tdata the injector with
// the open and close ticks, which are zero unless the action is reschedule.
// The APB port sets the injector count, the tdc tables and ticks per second;
// write it only while no request is in flight.
// A request passes a classify stage, the four-entry queue, the multiply
// stage and the output register. One request per cycle is sustained while
// m_tready is high; the stored open tick is read and written in the same
// output stage, so back-to-back requests to one injector see it. When the
// receiver stalls, the back end holds and the queue absorbs up to four
// requests before s_tready drops. Reset empties the pipeline, loads the
// register defaults and sets every stored open tick to the start-up value.
// ----------------------------------------------------------------------------
`default_nettype none

module injector_event_scheduler #(
	parameter int MAX_INJECTORS = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// injector, cam_angle, ticks_per_degree, now_tick, open_angle, pulse_seconds
	input  wire logic [ies_pkg::IN_DATA_W-1:0]  s_tdata,
	// cam_valid
	input  wire logic                           s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// injector_out, open_tick, close_tick
	output logic [ies_pkg::OUT_DATA_W-1:0]      m_tdata,
	// action
	output logic [1:0]                          m_tuser,
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [4:0]                     paddr,
	input  wire logic [63:0]                    pwdata,
	output logic [63:0]                         prdata,
	output logic                                pready
);
	import ies_pkg::*;

	logic [3:0]  count_q;
	logic [63:0] tdc_low_q;
	logic [63:0] tdc_high_q;
	logic [31:0] tps_q;
	logic [1:0]  reg_idx;
	logic        wr_en;

	logic  push, full, pop, empty;
	item_t wr_item, rd_item;

	// register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= COUNT_RESET;
			tdc_low_q  <= '0;
			tdc_high_q <= '0;
			tps_q      <= TPS_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_COUNT:    count_q    <= pwdata[3:0];
				REG_TDC_LOW:  tdc_low_q  <= pwdata;
				REG_TDC_HIGH: tdc_high_q <= pwdata;
				REG_TPS:      tps_q      <= pwdata[31:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COUNT:    prdata = {60'd0, count_q};
			REG_TDC_LOW:  prdata = tdc_low_q;
			REG_TDC_HIGH: prdata = tdc_high_q;
			REG_TPS:      prdata = {32'd0, tps_q};
			default:      prdata = '0;
		endcase
	end

	// classify
	ies_front #(
		.MAX_INJECTORS(MAX_INJECTORS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.injector_count (count_q),
		.tdc_table_low  (tdc_low_q),
		.tdc_table_high (tdc_high_q),
		.push           (push),
		.item           (wr_item),
		.full           (full)
	);

	// decoupling queue
	ies_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.full    (full),
		.pop     (pop),
		.rd_item (rd_item),
		.empty   (empty)
	);

	// execute
	ies_back #(
		.MAX_INJECTORS(MAX_INJECTORS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.rd_item          (rd_item),
		.empty            (empty),
		.pop              (pop),
		.ticks_per_second (tps_q),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser)
	);

endmodule

`default_nettype wire

// ----- hdl/ies_front.sv -----
// ----------------------------------------------------------------------------
// ies_front
// Accepts requests, checks eligibility and works out the angle distance.
// ----------------------------------------------------------------------------
`default_nettype none

module ies_front #(
	parameter int MAX_INJECTORS = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// injector, cam_angle, ticks_per_degree, now_tick, open_angle, pulse_seconds
	input  wire logic [ies_pkg::IN_DATA_W-1:0]  s_tdata,
	// cam_valid
	input  wire logic                           s_tuser,
	input  wire logic [3:0]                     injector_count,
	input  wire logic [63:0]                    tdc_table_low,
	input  wire logic [63:0]                    tdc_table_high,
	output logic                                push,
	output ies_pkg::item_t                      item,
	input  wire logic                           full
);
	import ies_pkg::*;

	logic        vld_s1;
	item_t       item_s1;

	logic [2:0]  inj;
	logic [15:0] cam;
	logic [23:0] tpd;
	logic [31:0] now;
	logic [15:0] open_ang;
	logic [23:0] pulse;
	logic [63:0] word;
	logic [15:0] tdc;
	logic [16:0] open_mod;
	logic [16:0] cam_f;
	logic signed [18:0] d1, d2, d3;
	logic        eligible;
	logic        advance;

	// unpack request
	assign inj      = s_tdata[2:0];
	assign cam      = s_tdata[18:3];
	assign tpd      = s_tdata[42:19];
	assign now      = s_tdata[74:43];
	assign open_ang = s_tdata[90:75];
	assign pulse    = s_tdata[114:91];

	// injector in use
	assign eligible = s_tuser && ({1'b0, inj} < injector_count)
		&& ({1'b0, inj} < 4'(MAX_INJECTORS));

	// tdc lookup
	assign word = inj[2] ? tdc_table_high : tdc_table_low;
	assign tdc  = word[{inj[1:0], 4'b0000} +: 16];

	// cam fold and distance wrap
	always_comb begin
		open_mod = ({1'b0, open_ang} >= DEG720) ? ({1'b0, open_ang} - DEG720)
			: {1'b0, open_ang};
		cam_f = ({1'b0, cam} > DEG360) ? ({1'b0, cam} - DEG360) : {1'b0, cam};
		d1 = signed'({3'b000, tdc}) + signed'({2'b00, open_mod})
			- signed'({2'b00, cam_f});
		d2 = (d1 > signed'({2'b00, DEG720})) ? (d1 - signed'({1'b0, DEG1440})) : d1;
		d3 = (d2 < 0) ? (d2 + signed'({2'b00, DEG720})) : d2;
	end

	// handshake
	assign advance  = !vld_s1 || !full;
	assign s_tready = advance;
	assign push     = vld_s1 && !full;
	assign item     = item_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			item_s1.inj        <= inj;
			item_s1.eligible   <= eligible;
			item_s1.zero_pulse <= (pulse == 24'd0);
			item_s1.ang_dist   <= d3[15:0];
			item_s1.tpd        <= tpd;
			item_s1.now        <= now;
			item_s1.pulse      <= pulse;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ies_queue.sv -----
// ----------------------------------------------------------------------------
// ies_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ies_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ies_pkg::item_t  wr_item,
	output logic                 full,
	input  wire logic            pop,
	output ies_pkg::item_t       rd_item,
	output logic                 empty
);
	import ies_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	item_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wr_item;
	end

endmodule

`default_nettype wire

// ----- hdl/ies_back.sv -----
// ----------------------------------------------------------------------------
// ies_back
// Scales distance and pulse to ticks, applies the skip test, keeps open ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module ies_back #(
	parameter int MAX_INJECTORS = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ies_pkg::item_t                 rd_item,
	input  wire logic                           empty,
	output logic                                pop,
	input  wire logic [31:0]                    ticks_per_second,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// injector_out, open_tick, close_tick
	output logic [ies_pkg::OUT_DATA_W-1:0]      m_tdata,
	// action
	output logic [1:0]                          m_tuser
);
	import ies_pkg::*;

	localparam int IW = (MAX_INJECTORS > 1) ? $clog2(MAX_INJECTORS) : 1;

	logic        vld_s1;
	logic [2:0]  inj_s1;
	logic        eligible_s1;
	logic        zero_s1;
	logic [31:0] now_s1;
	logic [31:0] soon_s1;
	logic [39:0] off_prod_s1;
	logic [55:0] pulse_prod_s1;

	logic [31:0] last_q [MAX_INJECTORS];

	logic        advance;
	logic [31:0] last;
	logic        pass;
	logic [31:0] open_tick;
	logic [31:0] close_tick;
	logic [1:0]  action;

	assign advance = !m_tvalid || m_tready;
	assign pop     = advance && !empty;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			inj_s1        <= rd_item.inj;
			eligible_s1   <= rd_item.eligible;
			zero_s1       <= rd_item.zero_pulse;
			now_s1        <= rd_item.now;
			soon_s1       <= rd_item.now + GUARD_TICKS;
			off_prod_s1   <= rd_item.tpd * rd_item.ang_dist;
			pulse_prod_s1 <= rd_item.pulse * ticks_per_second;
		end
	end

	// tick sums and wrap-aware skip test
	always_comb begin
		last       = last_q[inj_s1[IW-1:0]];
		pass       = (soon_s1 < last) || ((soon_s1 >= WRAP_HIGH) && (last < WRAP_LOW));
		open_tick  = now_s1 + off_prod_s1[37:6];
		close_tick = open_tick + pulse_prod_s1[55:24];
		if (!eligible_s1 || !pass) action = ACT_NONE;
		else if (zero_s1)          action = ACT_CANCEL;
		else                       action = ACT_RESCHED;
	end

	// stored open ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_INJECTORS; i++) last_q[i] <= RESET_TICK;
		end else if (advance && vld_s1 && (action == ACT_RESCHED)) begin
			last_q[inj_s1[IW-1:0]] <= open_tick;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			m_tuser <= action;
			if (action == ACT_RESCHED) begin
				m_tdata <= {5'b00000, close_tick, open_tick, inj_s1};
			end else begin
				m_tdata <= {5'b00000, 32'd0, 32'd0, inj_s1};
			end
		end
	end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the injector event scheduler.
// ----------------------------------------------------------------------------
// Requests go in on the s_ stream and results come back on the m_ stream.
// A scoreboard keeps its own copy of the registers and the stored open ticks,
// predicts the action and the ticks of every accepted request and checks the
// results in order. A directed part covers cam unknown, unused injectors,
// cancel, the skip test with its wrap case, cam fold and the distance wraps.
// Random phases then run engine timelines under several register settings,
// mostly with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import ies_pkg::*;

	localparam int INJ_SLOTS   = 8;
	localparam int STALL_LIMIT = 2000;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [2:0]  inj;
		logic        cam_valid;
		logic [15:0] cam_angle;
		logic [23:0] tpd;
		logic [31:0] now;
		logic [15:0] open_angle;
		logic [23:0] pulse;
	} sched_request_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  inj;
		logic [31:0] open_tick;
		logic [31:0] close_tick;
	} sched_result_t;

	// scoreboard with its own register copy and stored open ticks
	class schedule_checker;
		logic [3:0]     inj_count;
		logic [63:0]    tdc_lo;
		logic [63:0]    tdc_hi;
		logic [31:0]    tps;
		logic [31:0]    open_hist [INJ_SLOTS];
		sched_result_t  due_results [$];
		int             errors;

		function new();
			inj_count = COUNT_RESET;
			tdc_lo    = '0;
			tdc_hi    = '0;
			tps       = TPS_RESET;
			foreach (open_hist[i]) open_hist[i] = RESET_TICK;
			errors    = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [63:0] value);
			case (idx)
				REG_COUNT:    inj_count = value[3:0];
				REG_TDC_LOW:  tdc_lo    = value;
				REG_TDC_HIGH: tdc_hi    = value;
				REG_TPS:      tps       = value[31:0];
				default: ;
			endcase
		endfunction

		// predict the result of an accepted request
		function void add_request(sched_request_t r);
			sched_result_t e;
			int unsigned   in_use;
			logic [31:0]   soon;
			logic [31:0]   last;
			logic [15:0]   tdc;
			longint        cam;
			longint        ang_dist;
			u64_t          offset;
			u64_t          pulse_ticks;
			e.action     = ACT_NONE;
			e.inj        = r.inj;
			e.open_tick  = '0;
			e.close_tick = '0;
			in_use = (inj_count > INJ_SLOTS) ? INJ_SLOTS : inj_count;
			if (r.cam_valid && r.inj < in_use) begin
				soon = r.now + GUARD_TICKS;
				last = open_hist[r.inj];
				if (soon < last || (soon >= WRAP_HIGH && last < WRAP_LOW)) begin
					if (r.pulse == 0) begin
						e.action = ACT_CANCEL;
					end else begin
						tdc = r.inj[2] ? tdc_hi[16*r.inj[1:0] +: 16]
						               : tdc_lo[16*r.inj[1:0] +: 16];
						// fold the cam into the first turn
						cam = longint'(r.cam_angle);
						if (cam > longint'(DEG360)) cam -= longint'(DEG360);
						ang_dist = longint'(tdc) + longint'(r.open_angle % DEG720) - cam;
						if (ang_dist > longint'(DEG720)) ang_dist -= longint'(DEG1440);
						if (ang_dist < 0) ang_dist += longint'(DEG720);
						if (ang_dist < 0) ang_dist = 0;
						offset      = (u64_t'(r.tpd) * u64_t'(ang_dist)) >> 6;
						pulse_ticks = (u64_t'(r.pulse) * u64_t'(tps)) >> 24;
						e.open_tick  = r.now + offset[31:0];
						e.close_tick = e.open_tick + pulse_ticks[31:0];
						open_hist[r.inj] = e.open_tick;
						e.action = ACT_RESCHED;
					end
				end
			end
			due_results.push_back(e);
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_result(sched_result_t got);
			sched_result_t e;
			if (due_results.size() == 0) begin
				report($sformatf("result for injector %0d with no request waiting", got.inj));
			end else begin
				e = due_results.pop_front();
				if (got.action != e.action)
					report($sformatf("action %0d, expected %0d", got.action, e.action));
				if (got.inj != e.inj)
					report($sformatf("injector %0d, expected %0d", got.inj, e.inj));
				if (got.open_tick != e.open_tick)
					report($sformatf("open tick %0h, expected %0h", got.open_tick,
						e.open_tick));
				if (got.close_tick != e.close_tick)
					report($sformatf("close tick %0h, expected %0h", got.close_tick,
						e.close_tick));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// injector, cam_angle, ticks_per_degree, now_tick, open_angle, pulse_seconds
	logic [IN_DATA_W-1:0]   s_tdata;
	// cam_valid
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// injector_out, open_tick, close_tick
	logic [OUT_DATA_W-1:0]  m_tdata;
	// action
	logic [1:0]             m_tuser;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [4:0]             paddr;
	logic [63:0]            pwdata;
	logic [63:0]            prdata;
	logic                   pready;

	schedule_checker sb;
	bit              calm;
	logic [31:0]     engine_time;
	int              idle_cycles;

	injector_event_scheduler #(
		.MAX_INJECTORS(INJ_SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// result side stalls
	always @(negedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result({m_tuser, m_tdata[2:0], m_tdata[34:3], m_tdata[66:35]});
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic sched_request_t mk(logic [2:0] inj, logic cv, logic [15:0] cam,
			logic [23:0] tpd, logic [31:0] now, logic [15:0] open_angle,
			logic [23:0] pulse);
		sched_request_t r;
		r.inj        = inj;
		r.cam_valid  = cv;
		r.cam_angle  = cam;
		r.tpd        = tpd;
		r.now        = now;
		r.open_angle = open_angle;
		r.pulse      = pulse;
		return r;
	endfunction

	// one request, with random gaps before it
	task automatic send(sched_request_t r);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.cam_valid;
		s_tdata  <= {5'b0, r.pulse, r.open_angle, r.now, r.tpd, r.cam_angle, r.inj};
		do @(posedge clk); while (!s_tready);
		sb.add_request(r);
	endtask

	task automatic stop_requests();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.due_results.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// registers change only with the pipeline empty
	task automatic configure(logic [3:0] count, logic [63:0] lo, logic [63:0] hi,
			logic [31:0] tps);
		drain();
		repeat (4) @(posedge clk);
		apb_write(REG_COUNT, {60'b0, count});
		apb_write(REG_TDC_LOW, lo);
		apb_write(REG_TDC_HIGH, hi);
		apb_write(REG_TPS, {32'b0, tps});
	endtask

	// random requests along an engine timeline
	task automatic run_phase(int n, logic [31:0] start);
		sched_request_t r;
		engine_time = start;
		for (int i = 0; i < n; i++) begin
			r.inj        = 3'($urandom_range(7));
			r.cam_valid  = ($urandom_range(9) != 0);
			r.cam_angle  = 16'($urandom_range(46079));
			r.tpd        = ($urandom_range(3) == 0) ? 24'($urandom_range(24'hFFFFFF))
			                                        : 24'($urandom_range(2000));
			r.open_angle = 16'($urandom_range(16'hFFFF));
			if ($urandom_range(19) != 0) begin
				engine_time = engine_time + $urandom_range(30000);
				r.now = engine_time;
			end else if ($urandom_range(1) == 0) begin
				r.now = WRAP_HIGH - 32'd8 + $urandom_range(16);
			end else begin
				r.now = $urandom();
			end
			if ($urandom_range(15) == 0)
				r.pulse = '0;
			else if ($urandom_range(3) == 0)
				r.pulse = 24'($urandom_range(24'hFFFFFF));
			else
				r.pulse = 24'($urandom_range(200000));
			send(r);
		end
		stop_requests();
	endtask

	// stimulus
	initial begin
		sb          = new();
		calm        = 1'b0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		m_tready    = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset registers: four injectors, zero tdc
		send(mk(3'd0, 1'b0, 16'd100, 24'd1000, 32'd1000, 16'd0, 24'd1000));
		send(mk(3'd4, 1'b1, 16'd0, 24'd1000, 32'd1000, 16'd0, 24'd1000));
		send(mk(3'd0, 1'b1, 16'd0, 24'd0, 32'd0, 16'd0, 24'd0));
		send(mk(3'd0, 1'b1, 16'd0, 24'd0, 32'd100, 16'd0, 24'hFFFFFF));
		send(mk(3'd0, 1'b1, 16'd0, 24'd1000, 32'd100, 16'd0, 24'd5000));
		send(mk(3'd0, 1'b1, 16'd0, 24'd1000, 32'd95, 16'd0, 24'd5000));
		send(mk(3'd1, 1'b1, 16'd46079, 24'hFFFFFF, 32'hFFFFFFF0, 16'hFFFF, 24'd1));
		send(mk(3'd2, 1'b1, 16'd23040, 24'd64, 32'd5000, 16'd0, 24'd16777));
		send(mk(3'd3, 1'b1, 16'd23041, 24'd64, 32'd5000, 16'd46080, 24'd100));
		stop_requests();

		// count above the slot number, far tdc values, zero ticks per second
		configure(4'd15, {16'd50000, 16'hFFFF, 16'd0, 16'd23040},
			{16'hFFFF, 16'hFFFF, 16'd1, 16'd100}, 32'd0);
		send(mk(3'd7, 1'b1, 16'd0, 24'd64, 32'd2000, 16'd46079, 24'hFFFFFF));
		send(mk(3'd3, 1'b1, 16'd0, 24'd64, 32'd6000, 16'd0, 24'd500));
		send(mk(3'd4, 1'b1, 16'd0, 24'd64, 32'hFFFFFFF0, 16'd0, 24'd1000));
		send(mk(3'd4, 1'b1, 16'd0, 24'd64, 32'hFFFFFFF8, 16'd0, 24'd1000));
		send(mk(3'd5, 1'b1, 16'd46079, 24'hFFFFFF, 32'd0, 16'hFFFF, 24'd77));
		send(mk(3'd6, 1'b1, 16'd0, 24'd0, 32'd10, 16'd0, 24'd0));
		stop_requests();

		// random phases
		configure(4'd8, {$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom());
		run_phase(400, 32'hFFFFFFFF - 32'd2000000);
		configure(4'd0, {$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom());
		run_phase(40, $urandom());
		configure(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFFFFFF);
		calm = 1'b1;
		run_phase(300, $urandom());
		calm = 1'b0;
		configure(4'($urandom_range(1, 7)), {$urandom(), $urandom()},
			{$urandom(), $urandom()}, 32'd1);
		run_phase(300, $urandom());
		configure(4'd8, 64'd0, 64'd0, TPS_RESET);
		run_phase(200, $urandom());

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
